FILE: design/mad_pkg.sv
package mad_pkg;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic [7:0] fore_red;
    logic [7:0] fore_green;
    logic [7:0] fore_blue;
    logic [7:0] back_red;
    logic [7:0] back_green;
    logic [7:0] back_blue;
  } mad_in_t;

  typedef struct packed {
    logic [16:0] alpha_q16;
    logic [16:0] distortion_q16;
  } mad_out_t;

  localparam int unsigned OneQ16   = 65536;
  localparam int          DivBits  = 16;  // quotient bits below the integer bit
  localparam int          SqrtBits = 27;  // root bits: sqrt(3*(255*65536)^2) < 2^25
  localparam int          Lat      = DivBits + SqrtBits + 8;

endpackage

FILE: design/matting_alpha_distortion.sv
// Throughput: one request per cycle; busy is never asserted after reset.
// Each of the 16 restoring-divide steps and 27 square-root steps is its own
// register stage, so the long dependent chains set the latency, not the rate.
// Reset (rst, synchronous) clears all stage valid bits; payloads are not reset.
// The receiver cannot stall: a result is shown for exactly one cycle.
module matting_alpha_distortion (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  mad_pkg::mad_in_t  request,
  output logic              done,
  output mad_pkg::mad_out_t result
);
  import mad_pkg::*;

  // Stage 0: channel differences. e = C-B, d = F-B, 9-bit signed.
  logic              v0;
  logic signed [8:0] e0 [3];
  logic signed [8:0] d0 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
    e0[0] <= $signed({1'b0, request.pixel_red})   - $signed({1'b0, request.back_red});
    e0[1] <= $signed({1'b0, request.pixel_green}) - $signed({1'b0, request.back_green});
    e0[2] <= $signed({1'b0, request.pixel_blue})  - $signed({1'b0, request.back_blue});
    d0[0] <= $signed({1'b0, request.fore_red})    - $signed({1'b0, request.back_red});
    d0[1] <= $signed({1'b0, request.fore_green})  - $signed({1'b0, request.back_green});
    d0[2] <= $signed({1'b0, request.fore_blue})   - $signed({1'b0, request.back_blue});
  end

  assign busy = 1'b0;

  // Stage 1: dot products. |num| <= 3*255*255 < 2^18.
  logic               v1;
  logic signed [8:0]  e1 [3];
  logic signed [8:0]  d1 [3];
  logic signed [18:0] num1;
  logic        [17:0] den1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= v0;
    e1   <= e0;
    d1   <= d0;
    num1 <= 19'(e0[0] * d0[0]) + 19'(e0[1] * d0[1]) + 19'(e0[2] * d0[2]);
    den1 <= 18'(d0[0] * d0[0]) + 18'(d0[1] * d0[1]) + 18'(d0[2] * d0[2]);
  end

  // Stage 2: classify. Divide only in 0 < num < den; then num < 2^18.
  typedef enum logic [1:0] {AZero, AOne, ADiv} acls_t;
  logic              v2;
  logic signed [8:0] e2 [3];
  logic signed [8:0] d2 [3];
  acls_t             cls2;
  logic       [17:0] num2;
  logic       [17:0] den2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    e2   <= e1;
    d2   <= d1;
    num2 <= num1[17:0];
    den2 <= den1;
    if (den1 == '0 || num1 <= 0)          cls2 <= AZero;
    else if (num1 >= $signed({1'b0, den1})) cls2 <= AOne;
    else                                  cls2 <= ADiv;
  end

  // Divide pipeline: one restoring step per stage, remainder < den.
  logic              dv  [DivBits+1];
  logic signed [8:0] de  [DivBits+1][3];
  logic signed [8:0] dd  [DivBits+1][3];
  acls_t             dc  [DivBits+1];
  logic       [17:0] rem [DivBits+1];
  logic       [17:0] dvs [DivBits+1];
  logic       [15:0] quo [DivBits+1];

  always_comb begin
    dv[0]  = v2;
    de[0]  = e2;
    dd[0]  = d2;
    dc[0]  = cls2;
    rem[0] = num2;
    dvs[0] = den2;
    quo[0] = '0;
  end

  for (genvar s = 0; s < DivBits; s++) begin : g_div
    logic [18:0] trial;
    assign trial = {rem[s], 1'b0};
    always_ff @(posedge clk) begin
      if (rst) dv[s+1] <= 1'b0;
      else     dv[s+1] <= dv[s];
      de[s+1]  <= de[s];
      dd[s+1]  <= dd[s];
      dc[s+1]  <= dc[s];
      dvs[s+1] <= dvs[s];
      if (trial >= {1'b0, dvs[s]}) begin
        rem[s+1] <= 18'(trial - {1'b0, dvs[s]});
        quo[s+1] <= {quo[s][14:0], 1'b1};
      end else begin
        rem[s+1] <= trial[17:0];
        quo[s+1] <= {quo[s][14:0], 1'b0};
      end
    end
  end

  // Stage A: final alpha.
  logic              va;
  logic signed [8:0] ea [3];
  logic signed [8:0] da [3];
  logic       [16:0] alpha_a;

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else     va <= dv[DivBits];
    ea <= de[DivBits];
    da <= dd[DivBits];
    case (dc[DivBits])
      AZero:   alpha_a <= '0;
      AOne:    alpha_a <= 17'(OneQ16);
      default: alpha_a <= {1'b0, quo[DivBits]};
    endcase
  end

  // Stage B: residuals r = e*65536 - alpha*d, |r| < 2^25.
  logic               vb;
  logic        [16:0] alpha_b;
  logic signed [26:0] rb [3];

  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else     vb <= va;
    alpha_b <= alpha_a;
    for (int k = 0; k < 3; k++) begin
      rb[k] <= $signed({ea[k], 16'b0}) - 27'($signed({1'b0, alpha_a}) * da[k]);
    end
  end

  // Stage C: squares, one multiplier per channel.
  logic        vc;
  logic [16:0] alpha_c;
  logic [49:0] sq_c [3];

  always_ff @(posedge clk) begin
    if (rst) vc <= 1'b0;
    else     vc <= vb;
    alpha_c <= alpha_b;
    for (int k = 0; k < 3; k++) begin
      sq_c[k] <= 50'(rb[k] * rb[k]);
    end
  end

  // Stage D: sum of squares, < 2^52.
  logic        vd;
  logic [16:0] alpha_d;
  logic [53:0] sum_d;

  always_ff @(posedge clk) begin
    if (rst) vd <= 1'b0;
    else     vd <= vc;
    alpha_d <= alpha_c;
    sum_d   <= 54'(sq_c[0]) + 54'(sq_c[1]) + 54'(sq_c[2]);
  end

  // Square-root pipeline: one result bit per stage, MSB first.
  logic        sv  [SqrtBits+1];
  logic [16:0] sa  [SqrtBits+1];
  logic [53:0] srm [SqrtBits+1];
  logic [26:0] srt [SqrtBits+1];

  always_comb begin
    sv[0]  = vd;
    sa[0]  = alpha_d;
    srm[0] = sum_d;
    srt[0] = '0;
  end

  for (genvar s = 0; s < SqrtBits; s++) begin : g_sqrt
    localparam int B = SqrtBits - 1 - s;
    logic [55:0] tr;
    // (root + 2^B)^2 - root^2 = root*2^(B+1) + 2^(2B)
    assign tr = (56'(srt[s]) << (B + 1)) + (56'd1 << (2 * B));
    always_ff @(posedge clk) begin
      if (rst) sv[s+1] <= 1'b0;
      else     sv[s+1] <= sv[s];
      sa[s+1] <= sa[s];
      if (56'(srm[s]) >= tr) begin
        srm[s+1] <= 54'(56'(srm[s]) - tr);
        srt[s+1] <= srt[s] | (27'd1 << B);
      end else begin
        srm[s+1] <= srm[s];
        srt[s+1] <= srt[s];
      end
    end
  end

  // Stage E: divide root by 255 via reciprocal with one correction.
  logic        ve;
  logic [16:0] alpha_e;
  logic [26:0] root_e;
  logic [17:0] qe;

  always_ff @(posedge clk) begin
    if (rst) ve <= 1'b0;
    else     ve <= sv[SqrtBits];
    alpha_e <= sa[SqrtBits];
    root_e  <= srt[SqrtBits];
    // floor(x*65793/2^24) underestimates x/255 by at most one
    qe      <= 18'((45'(srt[SqrtBits]) * 45'd65793) >> 24);
  end

  logic [26:0] rem_e;
  assign rem_e = 27'(root_e - 27'(qe) * 27'd255);

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= ve;
    result.alpha_q16      <= alpha_e;
    result.distortion_q16 <= (rem_e >= 27'd255) ? 17'(qe + 18'd1) : qe[16:0];
  end

`ifndef SYNTHESIS
  a_alpha_range: assert property (@(posedge clk) disable iff (rst)
    done |-> result.alpha_q16 <= 17'(OneQ16))
    else $error("alpha above one");
  a_latency: assert property (@(posedge clk) disable iff (rst)
    v2 |-> ##(Lat - 2) done)
    else $error("result lost in pipeline");
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (dv[DivBits] && dc[DivBits] == ADiv) |-> rem[DivBits] < dvs[DivBits])
    else $error("divider remainder out of range");
`endif

endmodule

FILE: sim/matting_alpha_distortion_test.sv
`timescale 1ns / 1ps

module matting_alpha_distortion_test;
  import mad_pkg::*;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  mad_in_t  request;
  logic     done;
  mad_out_t result;

  // Expected alpha/distortion pairs, oldest first
  mad_out_t pending_results[$];
  int       error_count;
  longint   cycle_count;
  bit       idle_enabled;

  localparam longint CycleLimit = 200000;

  matting_alpha_distortion uut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Integer square root by bit pairs, floor result
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Project the pixel onto the fg-bg line, then measure what is left over
  function automatic mad_out_t predict_matte(input mad_in_t px);
    longint          diff_fb[3];
    longint          diff_cb[3];
    longint          proj;
    longint          norm;
    longint          alpha;
    longint          resid;
    longint unsigned sq_sum;
    mad_out_t        res;
    diff_cb[0] = longint'(px.pixel_red)   - longint'(px.back_red);
    diff_cb[1] = longint'(px.pixel_green) - longint'(px.back_green);
    diff_cb[2] = longint'(px.pixel_blue)  - longint'(px.back_blue);
    diff_fb[0] = longint'(px.fore_red)    - longint'(px.back_red);
    diff_fb[1] = longint'(px.fore_green)  - longint'(px.back_green);
    diff_fb[2] = longint'(px.fore_blue)   - longint'(px.back_blue);
    proj = 0;
    norm = 0;
    for (int k = 0; k < 3; k++) begin
      proj += diff_cb[k] * diff_fb[k];
      norm += diff_fb[k] * diff_fb[k];
    end
    // Clamp: no separation or behind the background gives 0, past fg gives 1
    if (norm == 0 || proj <= 0) alpha = 0;
    else if (proj >= norm) alpha = OneQ16;
    else alpha = (proj * OneQ16) / norm;
    sq_sum = 0;
    for (int k = 0; k < 3; k++) begin
      resid = diff_cb[k] * OneQ16 - alpha * diff_fb[k];
      if (resid < 0) resid = -resid;
      sq_sum += longint'(resid) * longint'(resid);
    end
    res.alpha_q16      = alpha[16:0];
    res.distortion_q16 = 17'(int_sqrt(sq_sum) / 255);
    return res;
  endfunction

  // Check each result against the oldest prediction
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: alpha_q16=%0d distortion_q16=%0d",
               result.alpha_q16, result.distortion_q16);
        error_count++;
      end else begin
        mad_out_t want;
        want = pending_results.pop_front();
        if (result.alpha_q16 !== want.alpha_q16) begin
          $error("alpha_q16 mismatch: expected %0d, actual %0d",
                 want.alpha_q16, result.alpha_q16);
          error_count++;
        end
        if (result.distortion_q16 !== want.distortion_q16) begin
          $error("distortion_q16 mismatch: expected %0d, actual %0d",
                 want.distortion_q16, result.distortion_q16);
          error_count++;
        end
      end
    end
  end

  // Abort on a hung run
  always @(posedge clk) begin
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Send one request; start stays high if the next request follows directly
  task automatic send_request(input mad_in_t px);
    if (idle_enabled && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    start   <= 1'b1;
    request <= px;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_matte(px));
    @(negedge clk);
  endtask

  function automatic mad_in_t make_pixel(input int c[3], input int f[3], input int b[3]);
    mad_in_t px;
    px.pixel_red  = 8'(c[0]); px.pixel_green = 8'(c[1]); px.pixel_blue = 8'(c[2]);
    px.fore_red   = 8'(f[0]); px.fore_green  = 8'(f[1]); px.fore_blue  = 8'(f[2]);
    px.back_red   = 8'(b[0]); px.back_green  = 8'(b[1]); px.back_blue  = 8'(b[2]);
    return px;
  endfunction

  // Corners, fg equal to bg, projection below zero and above one
  task automatic test_directed();
    send_request(make_pixel('{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}));
    send_request(make_pixel('{255, 255, 255}, '{255, 255, 255}, '{255, 255, 255}));
    send_request(make_pixel('{255, 255, 255}, '{0, 0, 0}, '{0, 0, 0}));
    send_request(make_pixel('{0, 0, 0}, '{128, 7, 200}, '{128, 7, 200}));
    send_request(make_pixel('{255, 0, 255}, '{9, 9, 9}, '{9, 9, 9}));
    send_request(make_pixel('{0, 0, 0}, '{255, 255, 255}, '{128, 128, 128}));
    send_request(make_pixel('{0, 255, 0}, '{255, 0, 255}, '{0, 255, 0}));
    send_request(make_pixel('{255, 255, 255}, '{128, 128, 128}, '{0, 0, 0}));
    send_request(make_pixel('{255, 0, 0}, '{0, 255, 255}, '{255, 0, 0}));
    send_request(make_pixel('{255, 255, 255}, '{255, 255, 255}, '{0, 0, 0}));
    send_request(make_pixel('{255, 255, 255}, '{0, 0, 0}, '{255, 255, 255}));
    send_request(make_pixel('{0, 0, 0}, '{255, 255, 255}, '{0, 0, 0}));
    send_request(make_pixel('{128, 128, 128}, '{255, 255, 255}, '{0, 0, 0}));
    send_request(make_pixel('{255, 0, 0}, '{0, 255, 0}, '{0, 0, 255}));
    send_request(make_pixel('{0, 255, 255}, '{255, 0, 0}, '{0, 0, 0}));
    send_request(make_pixel('{100, 50, 200}, '{101, 50, 200}, '{100, 50, 200}));
    send_request(make_pixel('{170, 85, 1}, '{255, 0, 254}, '{0, 255, 1}));
    send_request(make_pixel('{85, 170, 254}, '{0, 255, 1}, '{255, 0, 254}));
  endtask

  // Random colors; some draws share fg and bg, put the pixel near the line, or make fg and bg nearly equal
  task automatic test_random(input int count);
    mad_in_t px;
    int      pick;
    int      t;
    for (int n = 0; n < count; n++) begin
      px = mad_in_t'({$urandom(), $urandom(), $urandom()});
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        px.back_red = px.fore_red; px.back_green = px.fore_green;
        px.back_blue = px.fore_blue;
      end else if (pick <= 3) begin
        // Pixel near the fg-bg segment, lightly perturbed
        t = $urandom_range(0, 256);
        px.pixel_red   = 8'((px.fore_red   * t + px.back_red   * (256 - t)) / 256);
        px.pixel_green = 8'((px.fore_green * t + px.back_green * (256 - t)) / 256);
        px.pixel_blue  = 8'((px.fore_blue  * t + px.back_blue  * (256 - t)) / 256);
        px.pixel_red   = px.pixel_red ^ 8'($urandom_range(0, 3));
      end else if (pick == 4) begin
        // Near-equal fg and bg: tiny denominators
        px.fore_red   = px.back_red   ^ 8'($urandom_range(0, 1));
        px.fore_green = px.back_green ^ 8'($urandom_range(0, 1));
        px.fore_blue  = px.back_blue  ^ 8'($urandom_range(0, 1));
      end
      send_request(px);
    end
  endtask

  initial begin
    int drain;
    rst          = 1'b1;
    start        = 1'b0;
    request      = '0;
    error_count  = 0;
    cycle_count  = 0;
    idle_enabled = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random(550);
    // Final stretch runs back to back
    idle_enabled = 1'b0;
    test_random(200);
    start <= 1'b0;

    // Drain the pipeline, then allow a little extra for stray strobes
    drain = 0;
    while (pending_results.size() != 0 && drain < 10 * Lat) begin
      @(posedge clk);
      drain++;
    end
    repeat (Lat + 10) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      error_count++;
    end

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
